[sv/fsp_pkg.sv]
// Shared types, request codes and register defaults for the frame skip pacer.
package fsp_pkg;

    localparam logic [1:0] REQ_BEGIN  = 2'd0;
    localparam logic [1:0] REQ_MARK   = 2'd1;
    localparam logic [1:0] REQ_RECORD = 2'd2;

    localparam logic [1:0] CFG_FRAME_PERIOD   = 2'd0;
    localparam logic [1:0] CFG_SKIP_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_MAX_SKIPS      = 2'd2;
    localparam logic [1:0] CFG_MAX_DEBT       = 2'd3;

    localparam logic [31:0] RST_FRAME_PERIOD   = 32'd4468530;
    localparam logic [31:0] RST_SKIP_THRESHOLD = 32'd4021677;
    localparam logic [3:0]  RST_MAX_SKIPS      = 4'd3;
    localparam logic [3:0]  RST_MAX_DEBT       = 4'd4;
    localparam logic [3:0]  MAX_DEBT_LIMIT     = 4'd8;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] now_tick;
        logic [63:0] interval_ticks;
        logic [1:0]  discontinuity_reason;
    } t_in_item;

    typedef struct packed {
        logic               ok;
        logic [31:0]        sleep_ticks;
        logic signed [35:0] debt_ticks;
        logic [3:0]         consecutive_skips;
        logic [31:0]        skipped_presentations;
        logic [31:0]        resyncs;
        logic [31:0]        app_pauses;
        logic [31:0]        dump_pauses;
        logic [31:0]        debt_clamps;
        logic [31:0]        active_intervals;
        logic [63:0]        active_elapsed;
        logic [63:0]        requested_sleep;
    } t_out_item;

    // Effective register values, already forced into their legal ranges.
    typedef struct packed {
        logic [31:0] frame_period;
        logic [31:0] skip_threshold;
        logic [3:0]  max_consecutive_skips;
        logic [3:0]  max_debt_periods;
    } t_cfg;

endpackage

[sv/fsp_cfg.sv]
// Configuration registers of the frame skip pacer and their effective values.
module fsp_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    output fsp_pkg::t_cfg o_cfg
);
    import fsp_pkg::*;

    logic [31:0] r_frame_period;
    logic [31:0] r_skip_threshold;
    logic [3:0]  r_max_skips;
    logic [3:0]  r_max_debt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_period   <= RST_FRAME_PERIOD;
            r_skip_threshold <= RST_SKIP_THRESHOLD;
            r_max_skips      <= RST_MAX_SKIPS;
            r_max_debt       <= RST_MAX_DEBT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_PERIOD:   r_frame_period   <= i_cfg_data;
                CFG_SKIP_THRESHOLD: r_skip_threshold <= i_cfg_data;
                CFG_MAX_SKIPS:      r_max_skips      <= i_cfg_data[3:0];
                CFG_MAX_DEBT:       r_max_debt       <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.frame_period          = (r_frame_period == 32'd0) ? 32'd1 : r_frame_period;
        o_cfg.skip_threshold        = r_skip_threshold;
        o_cfg.max_consecutive_skips = r_max_skips;
        if (r_max_debt == 4'd0) begin
            o_cfg.max_debt_periods = 4'd1;
        end else if (r_max_debt > MAX_DEBT_LIMIT) begin
            o_cfg.max_debt_periods = MAX_DEBT_LIMIT;
        end else begin
            o_cfg.max_debt_periods = r_max_debt;
        end
    end

endmodule

[sv/fsp_core.sv]
// Pacing state, debt arithmetic and statistics counters; one item per enabled cycle.
module fsp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  fsp_pkg::t_in_item  i_item,
    input  fsp_pkg::t_cfg      i_cfg,
    output fsp_pkg::t_out_item o_result
);
    import fsp_pkg::*;

    function automatic logic [31:0] inc32(input logic [31:0] v);
        inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic logic [63:0] add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        add64 = s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    logic               r_started, n_started;
    logic [63:0]        r_last, n_last;
    logic signed [36:0] r_debt, n_debt;
    logic [3:0]         r_run, n_run;
    logic [1:0]         r_pending, n_pending;
    logic [31:0]        r_skip_cnt, n_skip_cnt;
    logic [31:0]        r_resync_cnt, n_resync_cnt;
    logic [31:0]        r_app_cnt, n_app_cnt;
    logic [31:0]        r_dump_cnt, n_dump_cnt;
    logic [31:0]        r_clamp_cnt, n_clamp_cnt;
    logic [31:0]        r_intv_cnt, n_intv_cnt;
    logic [63:0]        r_elapsed_tot, n_elapsed_tot;
    logic [63:0]        r_sleep_tot, n_sleep_tot;

    logic               w_ok;
    logic [32:0]        w_sleep;
    logic               w_disc;
    logic [63:0]        w_elapsed;
    logic [64:0]        w_diff;
    logic signed [38:0] w_delta;
    logic [35:0]        w_maxd;
    logic signed [38:0] w_maxd_s;
    logic signed [38:0] w_debt_x;
    logic signed [38:0] w_room;
    logic signed [38:0] w_sum;
    logic               w_clamp;
    logic signed [38:0] w_per_s;
    logic signed [38:0] w_neg_per;
    logic signed [38:0] w_thr_s;
    logic signed [38:0] w_debt_a;
    logic signed [38:0] w_debt_b;
    logic signed [38:0] w_sleep_full;
    logic               w_present;

    assign w_disc    = (r_pending != 2'd0);
    assign w_elapsed = i_item.now_tick - r_last;
    assign w_diff    = {1'b0, w_elapsed} - {33'd0, i_cfg.frame_period};

    // A positive excess too large for any ceiling saturates; it clamps either way.
    always_comb begin
        if (w_diff[64]) begin
            w_delta = signed'(w_diff[38:0]);
        end else if (|w_diff[63:37]) begin
            w_delta = signed'({2'b00, {37{1'b1}}});
        end else begin
            w_delta = signed'({2'b00, w_diff[36:0]});
        end
    end

    assign w_maxd       = 36'(i_cfg.frame_period) * 36'(i_cfg.max_debt_periods);
    assign w_maxd_s     = signed'({3'd0, w_maxd});
    assign w_debt_x     = 39'(r_debt);
    assign w_room       = w_maxd_s - w_debt_x;
    assign w_sum        = w_debt_x + w_delta;
    assign w_clamp      = (w_delta > 39'sd0) && (w_delta > w_room);
    assign w_per_s      = signed'({7'd0, i_cfg.frame_period});
    assign w_neg_per    = 39'sd0 - w_per_s;
    assign w_thr_s      = signed'({7'd0, i_cfg.skip_threshold});
    assign w_debt_a     = w_clamp ? w_maxd_s : w_sum;
    assign w_debt_b     = (w_debt_a < w_neg_per) ? w_neg_per : w_debt_a;
    assign w_sleep_full = w_per_s - w_debt_b;
    assign w_present    = (w_debt_b < w_thr_s) || (r_run >= i_cfg.max_consecutive_skips);

    always_comb begin
        n_started     = r_started;
        n_last        = r_last;
        n_debt        = r_debt;
        n_run         = r_run;
        n_pending     = r_pending;
        n_skip_cnt    = r_skip_cnt;
        n_resync_cnt  = r_resync_cnt;
        n_app_cnt     = r_app_cnt;
        n_dump_cnt    = r_dump_cnt;
        n_clamp_cnt   = r_clamp_cnt;
        n_intv_cnt    = r_intv_cnt;
        n_elapsed_tot = r_elapsed_tot;
        n_sleep_tot   = r_sleep_tot;
        w_ok          = 1'b0;
        w_sleep       = 33'd0;

        case (i_item.req_type)
            REQ_BEGIN: begin
                n_last    = i_item.now_tick;
                n_pending = 2'd0;
                if (!r_started || w_disc) begin
                    n_started = 1'b1;
                    w_ok      = 1'b1;
                    if (w_disc) begin
                        n_debt       = '0;
                        n_run        = 4'd0;
                        n_resync_cnt = inc32(r_resync_cnt);
                        if (r_pending[0]) n_app_cnt  = inc32(r_app_cnt);
                        if (r_pending[1]) n_dump_cnt = inc32(r_dump_cnt);
                    end
                end else begin
                    n_elapsed_tot = add64(r_elapsed_tot, w_elapsed);
                    n_intv_cnt    = inc32(r_intv_cnt);
                    n_debt        = w_debt_b[36:0];
                    if (w_clamp) n_clamp_cnt = inc32(r_clamp_cnt);
                    if (w_present) begin
                        n_run = 4'd0;
                        w_ok  = 1'b1;
                    end else begin
                        n_run      = r_run + 4'd1;
                        n_skip_cnt = inc32(r_skip_cnt);
                        if (w_debt_b < w_per_s) begin
                            w_sleep     = w_sleep_full[32:0];
                            n_sleep_tot = add64(r_sleep_tot, 64'(w_sleep_full[32:0]));
                        end
                    end
                end
            end
            REQ_MARK: begin
                n_pending = r_pending | i_item.discontinuity_reason;
            end
            REQ_RECORD: begin
                n_pending = 2'd0;
                if (w_disc) begin
                    n_debt       = '0;
                    n_run        = 4'd0;
                    n_resync_cnt = inc32(r_resync_cnt);
                    if (r_pending[0]) n_app_cnt  = inc32(r_app_cnt);
                    if (r_pending[1]) n_dump_cnt = inc32(r_dump_cnt);
                end else begin
                    n_elapsed_tot = add64(r_elapsed_tot, i_item.interval_ticks);
                    n_intv_cnt    = inc32(r_intv_cnt);
                    w_ok          = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started     <= 1'b0;
            r_last        <= '0;
            r_debt        <= '0;
            r_run         <= '0;
            r_pending     <= '0;
            r_skip_cnt    <= '0;
            r_resync_cnt  <= '0;
            r_app_cnt     <= '0;
            r_dump_cnt    <= '0;
            r_clamp_cnt   <= '0;
            r_intv_cnt    <= '0;
            r_elapsed_tot <= '0;
            r_sleep_tot   <= '0;
        end else if (i_go) begin
            r_started     <= n_started;
            r_last        <= n_last;
            r_debt        <= n_debt;
            r_run         <= n_run;
            r_pending     <= n_pending;
            r_skip_cnt    <= n_skip_cnt;
            r_resync_cnt  <= n_resync_cnt;
            r_app_cnt     <= n_app_cnt;
            r_dump_cnt    <= n_dump_cnt;
            r_clamp_cnt   <= n_clamp_cnt;
            r_intv_cnt    <= n_intv_cnt;
            r_elapsed_tot <= n_elapsed_tot;
            r_sleep_tot   <= n_sleep_tot;
        end
    end

    always_comb begin
        o_result.ok                    = w_ok;
        o_result.sleep_ticks           = w_sleep[31:0];
        o_result.debt_ticks            = n_debt[35:0];
        o_result.consecutive_skips     = n_run;
        o_result.skipped_presentations = n_skip_cnt;
        o_result.resyncs               = n_resync_cnt;
        o_result.app_pauses            = n_app_cnt;
        o_result.dump_pauses           = n_dump_cnt;
        o_result.debt_clamps           = n_clamp_cnt;
        o_result.active_intervals      = n_intv_cnt;
        o_result.active_elapsed        = n_elapsed_tot;
        o_result.requested_sleep       = n_sleep_tot;
    end

endmodule

[sv/frame_skip_pacer.sv]
// Top level of the frame skip pacer: input register, core and result register.
// The pacer takes one request per clock and returns one result per request
// via the input register and the result register, at a sustained rate of one
// item per cycle while the result side keeps taking results. Each request is
// evaluated combinationally between the two registers, where the debt update,
// the skip decision and all counters are settled together, so the next request
// already sees the updated state. Configuration writes take effect at once and
// should only be issued while no request is in flight.
module frame_skip_pacer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fsp_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fsp_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import fsp_pkg::*;

    t_cfg      w_cfg;
    t_out_item w_result;
    logic      w_adv;
    logic      w_go;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_go       = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (w_adv) r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) r_in <= i_in_item;
        if (w_go) r_out <= w_result;
    end

    fsp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    fsp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_go),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[sv/fsp_checker.sv]
// Port-level checks for the frame skip pacer and the bind that attaches them.
module fsp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input fsp_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input fsp_pkg::t_out_item o_out_item
);
    import fsp_pkg::*;

    logic        r_seen;
    logic [31:0] r_last_skips;
    logic        w_out_xfer;

    assign w_out_xfer = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen       <= 1'b0;
            r_last_skips <= '0;
        end else if (w_out_xfer) begin
            r_seen       <= 1'b1;
            r_last_skips <= o_out_item.skipped_presentations;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed or dropped while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while the result register is empty");

    a_sleep_only_on_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.sleep_ticks != 32'd0) |-> !o_out_item.ok)
        else $error("sleep requested on a presented frame");

    a_skips_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer && r_seen |-> o_out_item.skipped_presentations >= r_last_skips)
        else $error("skip counter decreased between transfers");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_item))
        else $error("input valid withdrawn or payload changed before its transfer");

endmodule

bind frame_skip_pacer fsp_checker u_fsp_checker (.*);

[test/frame_skip_pacer_test.sv]
// Self-checking testbench for the frame skip pacer with random flow control on both channels.
module frame_skip_pacer_test;
    import fsp_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_FRAME_PERIOD;
    logic [31:0] cfg_data = '0;

    frame_skip_pacer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Configuration as the pacer currently holds it.
    logic [31:0] cfg_period    = RST_FRAME_PERIOD;
    logic [31:0] cfg_threshold = RST_SKIP_THRESHOLD;
    logic [3:0]  cfg_max_skips = RST_MAX_SKIPS;
    logic [3:0]  cfg_max_debt  = RST_MAX_DEBT;

    // Pacing state as predicted.
    logic        pace_started  = 1'b0;
    logic [63:0] pace_last     = '0;
    longint      pace_debt     = 0;
    logic [3:0]  pace_run      = '0;
    logic [1:0]  pace_pending  = '0;
    logic [31:0] skip_total    = '0;
    logic [31:0] resync_total  = '0;
    logic [31:0] app_total     = '0;
    logic [31:0] dump_total    = '0;
    logic [31:0] clamp_total   = '0;
    logic [31:0] active_count  = '0;
    logic [63:0] active_sum    = '0;
    logic [63:0] sleep_sum     = '0;

    t_in_item  request_q[$];
    t_out_item result_q[$];
    int        queued = 0;
    int        checked = 0;
    int        errors = 0;
    logic [63:0] gen_now = '0;

    function automatic logic [31:0] inc_sat32(logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic logic [63:0] add_sat64(logic [63:0] v, logic [63:0] a);
        return (a > ~v) ? '1 : v + a;
    endfunction

    function automatic bit take_marks();
        logic [1:0] why;
        why = pace_pending;
        pace_pending = '0;
        if (why == 2'd0) return 1'b0;
        pace_debt = 0;
        pace_run = '0;
        resync_total = inc_sat32(resync_total);
        if (why[0]) app_total = inc_sat32(app_total);
        if (why[1]) dump_total = inc_sat32(dump_total);
        return 1'b1;
    endfunction

    function automatic bit log_active(logic [63:0] ticks);
        if (take_marks()) return 1'b0;
        active_sum = add_sat64(active_sum, ticks);
        active_count = inc_sat32(active_count);
        return 1'b1;
    endfunction

    function automatic bit pace_tick(logic [63:0] now, output logic [63:0] sleep);
        longint unsigned per, periods, elapsed, pos, s;
        longint delta, ceiling, floor_debt;
        sleep = '0;
        per = (cfg_period == 32'd0) ? 64'd1 : {32'd0, cfg_period};
        periods = (cfg_max_debt == 4'd0) ? 64'd1 :
                  (cfg_max_debt > MAX_DEBT_LIMIT) ? 64'd8 : {60'd0, cfg_max_debt};
        if (!pace_started) begin
            pace_started = 1'b1;
            pace_last = now;
            void'(take_marks());
            return 1'b1;
        end
        elapsed = now - pace_last;
        pace_last = now;
        if (!log_active(elapsed)) return 1'b1;
        if (elapsed >= per) begin
            pos = elapsed - per;
            delta = (pos > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'sh7FFF_FFFF_FFFF_FFFF : longint'(pos);
        end else begin
            delta = -longint'(per - elapsed);
        end
        ceiling = longint'(per * periods);
        if (delta > 0 && delta > ceiling - pace_debt) begin
            pace_debt = ceiling;
            clamp_total = inc_sat32(clamp_total);
        end else begin
            pace_debt = pace_debt + delta;
        end
        floor_debt = -longint'(per);
        if (pace_debt < floor_debt) pace_debt = floor_debt;
        if (pace_debt < longint'({32'd0, cfg_threshold}) || pace_run >= cfg_max_skips) begin
            pace_run = '0;
            return 1'b1;
        end
        pace_run = pace_run + 4'd1;
        skip_total = inc_sat32(skip_total);
        if (pace_debt < longint'(per)) begin
            s = per - longint'(pace_debt);
            sleep = s;
            if (s != 0) sleep_sum = add_sat64(sleep_sum, s);
        end
        return 1'b0;
    endfunction

    function automatic t_out_item predict_result(t_in_item it);
        t_out_item r;
        logic [63:0] sleep;
        bit ok;
        ok = 1'b0;
        sleep = '0;
        case (it.req_type)
            REQ_BEGIN: ok = pace_tick(it.now_tick, sleep);
            REQ_MARK: pace_pending = pace_pending | it.discontinuity_reason;
            REQ_RECORD: ok = log_active(it.interval_ticks);
            default: ;
        endcase
        r.ok = ok;
        r.sleep_ticks = sleep[31:0];
        r.debt_ticks = 36'(pace_debt);
        r.consecutive_skips = pace_run;
        r.skipped_presentations = skip_total;
        r.resyncs = resync_total;
        r.app_pauses = app_total;
        r.dump_pauses = dump_total;
        r.debt_clamps = clamp_total;
        r.active_intervals = active_count;
        r.active_elapsed = active_sum;
        r.requested_sleep = sleep_sum;
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    // Request driver: bursts of back-to-back transfers separated by random gaps.
    int       gap_left = 0;
    int       burst_left = 0;
    bit       drv_held = 1'b0;
    t_in_item drv_item = '0;

    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            drv_held = in_valid;
            if (in_valid && in_ready) begin
                result_q.push_back(predict_result(drv_item));
                drv_held = 1'b0;
            end
            if (!drv_held) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    drv_item = request_q.pop_front();
                    in_item <= drv_item;
                    in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: ready pattern switches among four random modes, with occasional hold-offs.
    int rx_cycle = 0;
    int rx_mode = 0;
    int hold_left = 0;
    bit long_hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
            if (!long_hold_done && request_q.size() > 100) begin
                hold_left = 400;
                long_hold_done = 1'b1;
            end else if (hold_left == 0 && $urandom_range(0, 499) == 0) begin
                hold_left = $urandom_range(10, 60);
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= $urandom_range(0, 1);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (rx_cycle % 8 != 0);
                endcase
            end
        end
    end

    t_out_item want;

    always @(posedge i_clk) begin
        if (rst_n && out_valid && out_ready) begin
            checked++;
            if (result_q.size() == 0) begin
                $error("result transfer with no request outstanding");
                errors++;
            end else begin
                want = result_q.pop_front();
                check_field("ok", want.ok, out_item.ok);
                check_field("sleep_ticks", want.sleep_ticks, out_item.sleep_ticks);
                check_field("debt_ticks", want.debt_ticks, out_item.debt_ticks);
                check_field("consecutive_skips", want.consecutive_skips,
                            out_item.consecutive_skips);
                check_field("skipped_presentations", want.skipped_presentations,
                            out_item.skipped_presentations);
                check_field("resyncs", want.resyncs, out_item.resyncs);
                check_field("app_pauses", want.app_pauses, out_item.app_pauses);
                check_field("dump_pauses", want.dump_pauses, out_item.dump_pauses);
                check_field("debt_clamps", want.debt_clamps, out_item.debt_clamps);
                check_field("active_intervals", want.active_intervals,
                            out_item.active_intervals);
                check_field("active_elapsed", want.active_elapsed, out_item.active_elapsed);
                check_field("requested_sleep", want.requested_sleep,
                            out_item.requested_sleep);
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_item make_item(logic [1:0] kind, logic [63:0] value);
        t_in_item it;
        it.req_type = kind;
        it.now_tick = rand64();
        it.interval_ticks = rand64();
        it.discontinuity_reason = $urandom_range(0, 3);
        case (kind)
            REQ_BEGIN: it.now_tick = value;
            REQ_MARK: it.discontinuity_reason = value[1:0];
            REQ_RECORD: it.interval_ticks = value;
            default: ;
        endcase
        return it;
    endfunction

    function automatic logic [63:0] frame_interval();
        logic [63:0] per;
        per = (cfg_period == 32'd0) ? 64'd1 : {32'd0, cfg_period};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return per - per / 8 + rand64() % (per / 8 + per / 4 + 1);
            5, 6: return per * $urandom_range(2, 4) + rand64() % (per + 1);
            7: return rand64() % (per + 1);
            8: return per;
            default: return per + per / 10 + rand64() % (per / 10 + 1);
        endcase
    endfunction

    task automatic push_item(t_in_item it);
        request_q.push_back(it);
        queued++;
    endtask

    task automatic push_tick(logic [63:0] elapsed);
        gen_now = gen_now + elapsed;
        push_item(make_item(REQ_BEGIN, gen_now));
    endtask

    task automatic push_jump(logic [63:0] now);
        gen_now = now;
        push_item(make_item(REQ_BEGIN, gen_now));
    endtask

    task automatic drain();
        wait (checked == queued);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apply_config(logic [31:0] period, logic [31:0] threshold,
                                logic [31:0] skips, logic [31:0] debt_periods);
        logic [1:0]  regs [4];
        logic [31:0] vals [4];
        regs = '{CFG_FRAME_PERIOD, CFG_SKIP_THRESHOLD, CFG_MAX_SKIPS, CFG_MAX_DEBT};
        vals = '{period, threshold, skips, debt_periods};
        for (int k = 0; k < 4; k++) begin
            @(posedge i_clk);
            cfg_we <= 1'b1;
            cfg_index <= regs[k];
            cfg_data <= vals[k];
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cfg_period = period;
        cfg_threshold = threshold;
        cfg_max_skips = skips[3:0];
        cfg_max_debt = debt_periods[3:0];
    endtask

    task automatic fill_random(int n);
        int done;
        int r;
        logic [1:0] why;
        done = 0;
        while (done < n) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                push_tick(frame_interval());
                done++;
            end else if (r < 80) begin
                why = $urandom_range(0, 3);
                push_item(make_item(REQ_MARK, why));
                if (why != 2'd0) begin
                    done++;
                    if ($urandom_range(0, 1) == 1) begin
                        push_jump(rand64());
                        done++;
                    end
                end
            end else if (r < 94) begin
                push_item(make_item(REQ_RECORD, $urandom_range(0, 1 << 20)));
                done++;
            end else if (r < 97) begin
                push_item(make_item(REQ_UNUSED, rand64()));
            end else begin
                push_tick(64'd0);
                done++;
            end
        end
    endtask

    initial begin
        logic [63:0] per;
        logic [31:0] p;
        per = {32'd0, RST_FRAME_PERIOD};
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        push_item(make_item(REQ_MARK, 64'd1));
        push_item(make_item(REQ_RECORD, 64'd5));
        push_item(make_item(REQ_RECORD, 64'hFF));
        push_item(make_item(REQ_MARK, 64'd2));
        push_jump(64'hFFFF_FFFF_FF80_0000);
        push_tick(per);
        push_tick(per * 2);
        push_tick(per + per / 2);
        push_tick(per);
        push_tick(per);
        push_tick(per / 2);
        push_tick(per - per * 3 / 10);
        push_tick(per + per / 4);
        push_tick(64'd0);
        push_tick(64'd0);
        push_tick(64'h8000_0000_0000_0000 + per + 5);
        push_item(make_item(REQ_MARK, 64'd0));
        push_item(make_item(REQ_UNUSED, rand64()));
        push_item(make_item(REQ_MARK, 64'd3));
        push_jump(rand64());
        push_tick(per);
        push_item(make_item(REQ_MARK, 64'd2));
        push_item(make_item(REQ_RECORD, 64'd1000));
        push_item(make_item(REQ_RECORD, 64'd1000));
        push_tick(per * 6);
        drain();

        apply_config(32'd1000, 32'd900, 32'd0, 32'd8);
        push_item(make_item(REQ_MARK, 64'd1));
        push_tick(64'd1000);
        push_tick(64'd10000);
        push_tick(64'd10000);
        drain();
        apply_config(32'd1000, 32'd900, 32'd0, 32'd1);
        push_tick(64'd1000);
        push_tick(64'd900);
        push_tick(64'd1001);
        drain();

        apply_config(32'd1000, 32'd900, 32'd3, 32'd4);
        fill_random(200);
        drain();
        apply_config(32'd1, 32'd0, 32'd15, 32'd8);
        fill_random(150);
        drain();
        apply_config(32'd0, 32'd0, 32'd0, 32'd0);
        fill_random(150);
        drain();
        apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd15, 32'd15);
        fill_random(150);
        drain();

        repeat (4) begin
            case ($urandom_range(0, 3))
                0, 1: p = $urandom_range(2, 20000);
                2: p = $urandom;
                default: p = $urandom_range(0, 3);
            endcase
            apply_config(p, 32'((64'(p) * $urandom_range(0, 12)) / 10),
                         {$urandom_range(0, 1) == 1 ? $urandom : 32'd0} & 32'hFFFF_FFF0
                             | 32'($urandom_range(0, 15)),
                         {$urandom_range(0, 1) == 1 ? $urandom : 32'd0} & 32'hFFFF_FFF0
                             | 32'($urandom_range(0, 15)));
            fill_random(250);
            drain();
        end

        push_item(make_item(REQ_RECORD, 64'hFFFF_FFFF_FFFF_FFFF));
        push_item(make_item(REQ_RECORD, 64'hFFFF_FFFF_FFFF_FFFF));
        push_tick(rand64());
        push_item(make_item(REQ_RECORD, rand64()));
        push_tick(frame_interval());
        push_tick(frame_interval());
        drain();
        repeat (10) @(posedge i_clk);

        if (result_q.size() != 0) begin
            $error("%0d expected results never arrived", result_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(12 * 600000);
        $display("simulation failed");
        $finish;
    end

endmodule
